### src/ssp_pkg.sv
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int unsigned MaxSlotsDef = 64;
  localparam int unsigned SizeW       = 21;
  localparam int unsigned KibW        = 11;
  localparam int unsigned KibShift    = 10;
  localparam logic [KibW-1:0] PoolKibRst = KibW'(256);

  // operation codes of an input word
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] offset;
    logic             busy;
  } slot_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_POP,
    S_DONE
  } state_e;

endpackage

### src/stack_slot_pool_allocator_core.sv
`timescale 1ns / 1ps
// Stack slot pool allocator.
// Input channel (in_valid_i/in_ready_o) carries one request word: allocate
// alloc_size_i bytes, or free the block at free_offset_i. Output channel
// (out_valid_o/out_ready_i) returns one word per request: ok, block offset
// and the bytes left above the bump pointer.
// The slot stack lives in a ring of MAX_SLOTS cells, newest slot at the head.
// Each request rotates the ring once around so every slot
// passes the head for matching; an unmatched allocate that fits then pushes a
// new slot, and a matched free then pops one idle slot per cycle off the top.
// A request passes through scan and finish to done, which loads out_valid_o;
// a matched free passes through pop between finish and done. One request is
// in work at a time, and the block returns to idle before taking the next.
// The output register lets the next request be taken while a result waits;
// if the receiver stalls, the block holds the finished result in its final
// step until the output register frees up.
// Reset: pool_kib = 256, the stack empty, no output pending. Writing pool_kib
// over the APB port also empties the pool.
module stack_slot_pool_allocator_core import ssp_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [SizeW-1:0] alloc_size_i,
  input  logic [SizeW-1:0] free_offset_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             ok_o,
  output logic [SizeW-1:0] block_offset_o,
  output logic [SizeW-1:0] space_left_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);

  state_e state_q, state_d;

  logic [KibW-1:0]  pool_kib_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [SizeW-1:0] bump_q, bump_d;
  logic [SizeW-1:0] free_q, free_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic             found_q, found_d;
  logic             op_q, op_d;
  logic [SizeW-1:0] req_size_q, req_size_d;
  logic [SizeW-1:0] req_off_q, req_off_d;
  logic             ok_q, ok_d;
  logic [SizeW-1:0] where_q, where_d;
  logic             out_valid_q, out_valid_d;
  logic             res_ok_q, res_ok_d;
  logic [SizeW-1:0] res_off_q, res_off_d;
  logic [SizeW-1:0] res_left_q, res_left_d;

  shift_e mode;
  slot_t  head, push_word, wrap_word;
  logic   cfg_wr, accept, hit, last_step, can_push, do_pop, out_free;

  assign pready     = 1'b1;
  assign prdata     = {{(32-KibW){1'b0}}, pool_kib_q};
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign last_step = (step_q == IdxW'(MAX_SLOTS - 1));
  assign hit = (CntW'(step_q) < count_q) && !found_q &&
               ((op_q == OpAlloc) ? (!head.busy && head.size == req_size_q)
                                  : (head.offset == req_off_q));
  assign can_push = (free_q >= req_size_q) && (count_q < CntW'(MAX_SLOTS));
  assign do_pop   = (count_q != '0) && !head.busy;

  ssp_chain #(
    .Depth (MAX_SLOTS)
  ) u_chain (
    .clk_i  (clk_i),
    .mode_i (mode),
    .push_i (push_word),
    .wrap_i (wrap_word),
    .head_o (head)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (last_step) state_d = S_FINISH;
      S_FINISH: state_d = (op_q == OpFree && found_q) ? S_POP : S_DONE;
      S_POP:    if (!do_pop) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mode        = SH_HOLD;
    push_word   = '{size: req_size_q, offset: bump_q, busy: 1'b1};
    wrap_word   = head;
    count_d     = count_q;
    bump_d      = bump_q;
    free_d      = free_q;
    step_d      = step_q;
    found_d     = found_q;
    op_d        = op_q;
    req_size_d  = req_size_q;
    req_off_d   = req_off_q;
    ok_d        = ok_q;
    where_d     = where_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_ok_d    = res_ok_q;
    res_off_d   = res_off_q;
    res_left_d  = res_left_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = operation_i;
          req_size_d = alloc_size_i;
          req_off_d  = free_offset_i;
          step_d     = '0;
          found_d    = 1'b0;
          ok_d       = 1'b0;
          where_d    = '0;
        end
      end
      S_SCAN: begin
        // rotate: the head goes round to the top, marked on a hit
        mode   = SH_UP;
        step_d = step_q + 1'b1;
        if (hit) begin
          wrap_word.busy = (op_q == OpAlloc);
          found_d        = 1'b1;
          ok_d           = 1'b1;
          if (op_q == OpAlloc) where_d = head.offset;
        end
      end
      S_FINISH: begin
        if (op_q == OpAlloc && !found_q && can_push) begin
          mode    = SH_DOWN;
          count_d = count_q + 1'b1;
          bump_d  = bump_q + req_size_q;
          free_d  = free_q - req_size_q;
          ok_d    = 1'b1;
          where_d = bump_q;
        end
      end
      S_POP: begin
        if (do_pop) begin
          mode    = SH_UP;
          count_d = count_q - 1'b1;
          bump_d  = bump_q - head.size;
          free_d  = free_q + head.size;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_ok_d    = ok_q;
          res_off_d   = where_q;
          res_left_d  = free_q;
        end
      end
      default: ;
    endcase
    if (cfg_wr) begin
      count_d = '0;
      bump_d  = '0;
      free_d  = {pwdata[KibW-1:0], {KibShift{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_kib_q  <= PoolKibRst;
      count_q     <= '0;
      bump_q      <= '0;
      free_q      <= {PoolKibRst, {KibShift{1'b0}}};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bump_q      <= bump_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) pool_kib_q <= pwdata[KibW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    found_q    <= found_d;
    op_q       <= op_d;
    req_size_q <= req_size_d;
    req_off_q  <= req_off_d;
    ok_q       <= ok_d;
    where_q    <= where_d;
    res_ok_q   <= res_ok_d;
    res_off_q  <= res_off_d;
    res_left_q <= res_left_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = res_ok_q;
  assign block_offset_o = res_off_q;
  assign space_left_o   = res_left_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SLOTS))
    else $error("slot count above table depth");

  a_space_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SizeW'(bump_q + free_q) == {pool_kib_q, {KibShift{1'b0}}})
    else $error("bump pointer and free bytes do not add up to the pool");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && last_step) |=> state_q == S_FINISH)
    else $error("ring rotation did not end after one full turn");
`endif

endmodule

### src/ssp_cell.sv
`timescale 1ns / 1ps
module ssp_cell import ssp_pkg::*; (
  input  logic   clk_i,
  input  shift_e mode_i,
  input  slot_t  lo_i,
  input  slot_t  hi_i,
  output slot_t  q_o
);

  slot_t slot_q, slot_d;

  always_comb begin
    unique case (mode_i)
      SH_UP:   slot_d = hi_i;
      SH_DOWN: slot_d = lo_i;
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign q_o = slot_q;

endmodule

### src/ssp_chain.sv
`timescale 1ns / 1ps
module ssp_chain import ssp_pkg::*; #(
  parameter int unsigned Depth = MaxSlotsDef
) (
  input  logic   clk_i,
  input  shift_e mode_i,
  input  slot_t  push_i,
  input  slot_t  wrap_i,
  output slot_t  head_o
);

  slot_t cell_q [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    slot_t lo, hi;
    if (i == 0) begin : g_bot
      assign lo = push_i;
    end else begin : g_mid_lo
      assign lo = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_top
      assign hi = wrap_i;
    end else begin : g_mid_hi
      assign hi = cell_q[i+1];
    end
    ssp_cell u_cell (
      .clk_i  (clk_i),
      .mode_i (mode_i),
      .lo_i   (lo),
      .hi_i   (hi),
      .q_o    (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule
